// ===== rtl/core/pwt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared widths, request codes and record types of the process watch table.
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

   localparam int unsigned DEF_SLOTS = 8;

   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 32;
   localparam int STAMP_W = 64;
   localparam int SLOT_W  = 3;
   localparam int KIND_W  = 2;

   localparam int REQ_TDATA_W = 3 * ADDR_W + STAMP_W;  // 112 bits, whole bytes
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 1;

   localparam logic [KIND_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_ADD    = 2'd1;
   localparam logic [KIND_W-1:0] REQ_INVOKE = 2'd2;

   // One table entry as held in the slot memory.
   typedef struct packed {
      logic [ADDR_W-1:0]  process;
      logic [ADDR_W-1:0]  tstart;
      logic [ADDR_W-1:0]  tend;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // One response item.
   typedef struct packed {
      logic               status;
      logic [SLOT_W-1:0]  slot;
      logic               was_present;
      logic               register_region;
      logic [ADDR_W-1:0]  region_start;
      logic [ADDR_W-1:0]  region_length;
      logic [COUNT_W-1:0] invoke_count;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MATCH = 4'b0010,
      ST_FREE  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/process_watch_table_unit.sv =====
// ----------------------------------------------------------------------------
// process_watch_table_unit
// Table of watched processes with clear, add and invoke requests.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream, one transfer per request, with the
// request kind in req_tuser. Each request gives exactly one response transfer
// on the rsp_ stream, with the failure flag in rsp_tuser.
// The entries live in a single-port-read memory that one sequencer scans one
// slot per cycle. A clear goes from accept straight to the response state.
// An invoke or an add that finds its entry overlaps one read and one compare
// a slot. An add that must allocate scans the used marks again, one per
// cycle. req_tready is high only while the sequencer is idle.
// The response sits in an output register; the next request is accepted
// while it waits, and its result is held until the receiver takes the
// previous one. Reset drops all used marks at once and empties the output
// register; entry contents are not cleared and only matter for used slots.
// ----------------------------------------------------------------------------
`default_nettype none

module process_watch_table_unit #(
   parameter int unsigned SLOTS = pwt_pkg::DEF_SLOTS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // process_id[15:0], thread_start[31:16], return_addr[47:32], timestamp[111:48]
   input  wire logic [pwt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [pwt_pkg::KIND_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // slot[2:0], was_present[3], register_region[4], region_start[20:5],
   // region_length[36:21], invoke_count[68:37], zero[71:69]
   output logic [pwt_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // status[0]
   output logic [pwt_pkg::RSP_TUSER_W-1:0]      rsp_tuser
);
   import pwt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ADDR_W-1:0]  pid_ff, pid_in;
   logic [ADDR_W-1:0]  ts_ff, ts_in;
   logic [ADDR_W-1:0]  te_ff, te_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   result_type         res_ff, res_in;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic               rsp_vld_ff, rsp_vld_in;
   result_type         rsp_ff, rsp_in;

   entry_type          mem [SLOTS];
   entry_type          rd_data_ff;
   entry_type          wr_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;

   logic               req_fire;
   logic               hit;
   logic [IDX_W-1:0]   free_idx;
   logic [ADDR_W-1:0]  end_addr;
   logic [COUNT_W-1:0] count_inc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Compare stage of the match scan: the entry read in the previous cycle.
   assign hit = rd_vld_ff && used_ff[rd_idx_ff] && (rd_data_ff.tstart == ts_ff) &&
                ((kind_ff != REQ_ADD) || (rd_data_ff.process == pid_ff));

   assign free_idx  = scan_ff[IDX_W-1:0];
   assign end_addr  = (ts_ff != '0) ? te_ff : '0;
   assign count_inc = rd_data_ff.count + COUNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      kind_in    = kind_ff;
      pid_in     = pid_ff;
      ts_in      = ts_ff;
      te_in      = te_ff;
      stamp_in   = stamp_ff;
      scan_in    = scan_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      res_in     = res_ff;
      res_idx_in = res_idx_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = rd_idx_ff;
      wr_data    = rd_data_ff;
      rd_addr    = scan_ff[IDX_W-1:0];

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               pid_in   = req_tdata[ADDR_W-1:0];
               ts_in    = req_tdata[2*ADDR_W-1:ADDR_W];
               te_in    = req_tdata[3*ADDR_W-1:2*ADDR_W];
               stamp_in = req_tdata[REQ_TDATA_W-1:3*ADDR_W];
               res_in   = '0;
               scan_in  = '0;
               unique case (req_tuser)
                  REQ_CLEAR: begin
                     used_in  = '0;
                     state_in = ST_RESP;
                  end
                  REQ_ADD, REQ_INVOKE: begin
                     state_in = ST_MATCH;
                  end
                  default: begin
                     res_in.status = 1'b1;
                     state_in      = ST_RESP;
                  end
               endcase
            end
         end
         ST_MATCH: begin
            // Reads run one slot ahead of the compare.
            if (scan_ff != SLOTS_CNT) begin
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
            end
            if (hit) begin
               rd_vld_in  = 1'b0;
               res_in.slot = SLOT_W'(rd_idx_ff);
               res_idx_in = rd_idx_ff;
               if (kind_ff == REQ_ADD) begin
                  res_in.was_present = 1'b1;
               end else begin
                  wr_en                = 1'b1;
                  wr_data.count        = count_inc;
                  wr_data.stamp        = stamp_ff;
                  res_in.invoke_count  = count_inc;
               end
               state_in = ST_RESP;
            end else if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
               rd_vld_in = 1'b0;
               if (kind_ff == REQ_ADD) begin
                  scan_in  = '0;
                  state_in = ST_FREE;
               end else begin
                  res_in.status = 1'b1;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_FREE: begin
            if (!used_ff[free_idx]) begin
               used_in[free_idx] = 1'b1;
               wr_en             = 1'b1;
               wr_addr           = free_idx;
               wr_data.process   = pid_ff;
               wr_data.tstart    = ts_ff;
               wr_data.tend      = end_addr;
               wr_data.count     = '0;
               wr_data.stamp     = '0;
               res_in.slot       = SLOT_W'(free_idx);
               res_idx_in        = free_idx;
               if ((ts_ff != '0) && (end_addr != '0)) begin
                  res_in.register_region = 1'b1;
                  res_in.region_start    = ts_ff;
                  res_in.region_length   = end_addr - ts_ff;
               end
               state_in = ST_RESP;
            end else if (free_idx == LAST_IDX) begin
               res_in.status = 1'b1;
               state_in      = ST_RESP;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_in     = res_ff;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      pid_ff     <= pid_in;
      ts_ff      <= ts_in;
      te_ff      <= te_in;
      stamp_ff   <= stamp_in;
      scan_ff    <= scan_in;
      rd_idx_ff  <= rd_idx_in;
      res_ff     <= res_in;
      res_idx_ff <= res_idx_in;
      rsp_ff     <= rsp_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000, rsp_ff.invoke_count, rsp_ff.region_length,
                        rsp_ff.region_start, rsp_ff.register_region,
                        rsp_ff.was_present, rsp_ff.slot};

   // A clear transfer drops every used mark by the next cycle.
   a_clear_drops_all: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == REQ_CLEAR)) |=> (used_ff == '0))
      else $error("used marks survive a clear");

   // A successful add or invoke always reports a slot that is in use.
   a_result_slot_used: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESP) && !res_ff.status && (kind_ff != REQ_CLEAR))
      |-> used_ff[res_idx_ff])
      else $error("success reported for an unused slot");

   // The compare stage never looks past the last slot.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (32'(rd_idx_ff) < SLOTS))
      else $error("scan index beyond the table");

   // Outside a clear the number of used slots never falls.
   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (req_tuser == REQ_CLEAR))
      |=> ($countones(used_ff) >= $past($countones(used_ff))))
      else $error("used slot lost without a clear");

endmodule

`default_nettype wire

// ===== tb/sv/pwt_checker.sv =====
// ----------------------------------------------------------------------------
// pwt_checker
// Watches both streams of the process watch table and checks every response.
// ----------------------------------------------------------------------------
// Each request transfer updates a private copy of the watch table and queues
// the response that the table should give. Each response transfer is compared
// field by field with the oldest queued response. The number of mismatches
// and the number of responses still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module pwt_checker #(
   parameter int unsigned SLOTS = pwt_pkg::DEF_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // process_id[15:0], thread_start[31:16], return_addr[47:32], timestamp[111:48]
   input  logic [pwt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [pwt_pkg::KIND_W-1:0]      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot[2:0], was_present[3], register_region[4], region_start[20:5],
   // region_length[36:21], invoke_count[68:37], zero[71:69]
   input  logic [pwt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[0]
   input  logic [pwt_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pwt_pkg::*;

   logic                 watch_used  [SLOTS];
   entry_type            watch_entry [SLOTS];
   result_type           owed_responses [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: response mismatch on %s: got 0x%0h, expected 0x%0h",
               $realtime, what, got, want);
      fail_count = fail_count + 1;
   endtask

   // Applies one request to the table copy and returns the response it owes.
   function automatic result_type watch_table_response(
         input logic [KIND_W-1:0]  kind,
         input logic [ADDR_W-1:0]  pid,
         input logic [ADDR_W-1:0]  tstart,
         input logic [ADDR_W-1:0]  tend,
         input logic [STAMP_W-1:0] stamp);
      result_type        r;
      logic [ADDR_W-1:0] end_addr;
      bit                done;
      r    = '0;
      done = 1'b0;
      case (kind)
         REQ_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) watch_used[i] = 1'b0;
         end
         REQ_ADD: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && watch_used[i] && watch_entry[i].process == pid &&
                   watch_entry[i].tstart == tstart) begin
                  r.slot        = 3'(i);
                  r.was_present = 1'b1;
                  done          = 1'b1;
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && !watch_used[i]) begin
                  // A null thread keeps no end bound.
                  end_addr              = (tstart != '0) ? tend : '0;
                  watch_used[i]         = 1'b1;
                  watch_entry[i].process = pid;
                  watch_entry[i].tstart = tstart;
                  watch_entry[i].tend   = end_addr;
                  watch_entry[i].count  = '0;
                  watch_entry[i].stamp  = '0;
                  r.slot                = 3'(i);
                  if (tstart != '0 && end_addr != '0) begin
                     r.register_region = 1'b1;
                     r.region_start    = tstart;
                     r.region_length   = end_addr - tstart;
                  end
                  done = 1'b1;
               end
            end
            if (!done) r.status = 1'b1;
         end
         REQ_INVOKE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && watch_used[i] && watch_entry[i].tstart == tstart) begin
                  watch_entry[i].count = watch_entry[i].count + COUNT_W'(1);
                  watch_entry[i].stamp = stamp;
                  r.slot               = 3'(i);
                  r.invoke_count       = watch_entry[i].count;
                  done                 = 1'b1;
               end
            end
            if (!done) r.status = 1'b1;
         end
         default: r.status = 1'b1;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) watch_used[i] = 1'b0;
         owed_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_responses.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[63:0], 64'd0);
            end else begin
               want = owed_responses.pop_front();
               if (rsp_tuser[0] !== want.status)
                  report_mismatch("status", 64'(rsp_tuser[0]), 64'(want.status));
               if (rsp_tdata[2:0] !== want.slot)
                  report_mismatch("slot", 64'(rsp_tdata[2:0]), 64'(want.slot));
               if (rsp_tdata[3] !== want.was_present)
                  report_mismatch("was_present", 64'(rsp_tdata[3]),
                                  64'(want.was_present));
               if (rsp_tdata[4] !== want.register_region)
                  report_mismatch("register_region", 64'(rsp_tdata[4]),
                                  64'(want.register_region));
               if (rsp_tdata[20:5] !== want.region_start)
                  report_mismatch("region_start", 64'(rsp_tdata[20:5]),
                                  64'(want.region_start));
               if (rsp_tdata[36:21] !== want.region_length)
                  report_mismatch("region_length", 64'(rsp_tdata[36:21]),
                                  64'(want.region_length));
               if (rsp_tdata[68:37] !== want.invoke_count)
                  report_mismatch("invoke_count", 64'(rsp_tdata[68:37]),
                                  64'(want.invoke_count));
               if (rsp_tdata[71:69] !== 3'b000)
                  report_mismatch("padding", 64'(rsp_tdata[71:69]), 64'd0);
            end
         end
         if (req_tvalid && req_tready) begin
            owed_responses.push_back(watch_table_response(req_tuser,
               req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
               req_tdata[111:48]));
         end
      end
      pending_count = owed_responses.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the process watch table unit.
// ----------------------------------------------------------------------------
// A directed pass walks the table through empty, null-thread and zero-end
// adds, repeated adds, a full table, invokes of known and unknown threads,
// clears and the undefined request code. A random pass then draws process ids
// and thread starts from small pools so that hits, fills and full tables are
// common. Both sides stall at random, except in one quiet stretch. Checking
// is done by pwt_checker; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pwt_pkg::*;

   localparam logic [KIND_W-1:0] REQ_UNDEFINED = 2'd3;
   localparam int RANDOM_ITEMS = 550;
   localparam int POOL_SIZE    = 6;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   int                     fail_count;
   int                     pending_count;
   int                     stall_cycles;
   logic                   quiet;
   logic [ADDR_W-1:0]      pid_pool [POOL_SIZE];
   logic [ADDR_W-1:0]      thread_pool [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   process_watch_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pwt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Outside the quiet stretch the receiver refuses at random, about 28 percent of the time.
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Holds one request on the bus until its transfer, after a random gap.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [ADDR_W-1:0] pid,
                               input logic [ADDR_W-1:0] tstart,
                               input logic [ADDR_W-1:0] tend,
                               input logic [STAMP_W-1:0] stamp);
      while (!quiet && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {stamp, tend, tstart, pid};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
   endtask

   task automatic refill_pools();
      for (int k = 0; k < POOL_SIZE; k++) begin
         pid_pool[k]    = ADDR_W'($urandom);
         thread_pool[k] = ($urandom_range(7) == 0) ? '0 : ADDR_W'($urandom);
      end
   endtask

   initial begin
      int                 pick;
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  pid;
      logic [ADDR_W-1:0]  tstart;
      logic [ADDR_W-1:0]  tend;
      logic [STAMP_W-1:0] stamp;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = REQ_CLEAR;
      quiet        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass.
      send_request(REQ_INVOKE, 16'h0000, 16'h0000, 16'h0000, 64'd0);
      send_request(REQ_UNDEFINED, 16'h0000, 16'h0000, 16'h0000, 64'd0);
      send_request(REQ_ADD, 16'h0000, 16'h0000, 16'hFFFF, 64'd0);
      send_request(REQ_INVOKE, 16'hFFFF, 16'h0000, 16'hFFFF, 64'h0123_4567_89AB_CDEF);
      send_request(REQ_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_ADD, 16'hFFFF, 16'hFFFF, 16'h1234, 64'd0);
      send_request(REQ_ADD, 16'h0001, 16'h8000, 16'h0000, 64'd0);
      send_request(REQ_ADD, 16'h0002, 16'h0010, 16'h0008, 64'd0);
      for (int k = 0; k < 4; k++) begin
         send_request(REQ_ADD, 16'h0100 + 16'(k), 16'h4000 + 16'(k * 16), 16'h4100,
                      64'd0);
      end
      // The table is full now.
      send_request(REQ_ADD, 16'hABCD, 16'h5555, 16'hAAAA, 64'd0);
      send_request(REQ_INVOKE, 16'h0000, 16'hFFFF, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_INVOKE, 16'h0000, 16'hFFFF, 16'h0000, 64'd0);
      send_request(REQ_INVOKE, 16'h0000, 16'h7777, 16'h0000, 64'd1);
      send_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_INVOKE, 16'h0000, 16'hFFFF, 16'h0000, 64'd2);
      send_request(REQ_ADD, 16'h5A5A, 16'hA5A5, 16'h5A5A, 64'd0);
      send_request(REQ_INVOKE, 16'h0000, 16'hA5A5, 16'h0000, 64'd3);
      send_request(REQ_UNDEFINED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 64'd0);

      // Random pass over a small key space, so that entries recur.
      refill_pools();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet  <= (n >= 250 && n < 350);
         pick   = $urandom_range(99);
         pid    = ADDR_W'($urandom);
         tstart = ADDR_W'($urandom);
         tend   = ($urandom_range(9) == 0) ? '0 : ADDR_W'($urandom);
         stamp  = {$urandom, $urandom};
         if (pick < 45) begin
            kind = REQ_ADD;
            if ($urandom_range(9) != 0) pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(9) != 0) tstart = thread_pool[$urandom_range(POOL_SIZE - 1)];
         end else if (pick < 87) begin
            kind = REQ_INVOKE;
            if ($urandom_range(99) < 85) begin
               tstart = thread_pool[$urandom_range(POOL_SIZE - 1)];
            end
         end else if (pick < 94) begin
            kind = REQ_CLEAR;
            if ($urandom_range(1) == 0) refill_pools();
         end else begin
            kind = REQ_UNDEFINED;
         end
         send_request(kind, pid, tstart, tend, stamp);
      end
      req_tvalid <= 1'b0;
      quiet      <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
